// ----- src/vfcs_pkg.sv -----
package vfcs_pkg;

	localparam int MAX_LEN = 64;
	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W = $clog2(MAX_LEN + 1);

	typedef logic [7:0] byte_t;
	typedef logic [8:0] sort_key_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0] count_t;

	localparam byte_t VOWEL_A = 8'h61;
	localparam byte_t VOWEL_E = 8'h65;
	localparam byte_t VOWEL_I = 8'h69;
	localparam byte_t VOWEL_O = 8'h6f;
	localparam byte_t VOWEL_U = 8'h75;

	function automatic sort_key_t sort_key(input byte_t b);
		logic vowel;
		vowel = (b == VOWEL_A) || (b == VOWEL_E) || (b == VOWEL_I) ||
			(b == VOWEL_O) || (b == VOWEL_U);
		return {~vowel, b};
	endfunction

endpackage

// ----- src/vowel_first_char_sorter.sv -----
// Takes one string byte per transaction and keeps the string sorted in a 64-entry
// memory, lowercase vowels first, each part in byte order. A byte is inserted by
// shifting the larger stored bytes up one entry per cycle through the memory's
// read and write ports, so a transaction holds busy until every stored byte that
// ranks above the new byte has moved up and the new byte is written. A byte that
// arrives while the store is full is dropped and sets the overflow flag. On the
// final byte the block then starts the read and streams the stored bytes on
// consecutive cycles, each marked by strobe for one cycle only; the receiver must
// take every result as it comes. end_of_string marks the last byte, overflow is
// set on every byte of a string that lost bytes. Busy falls in the cycle that
// carries the last strobe, so the next string can start at once.
module vowel_first_char_sorter
	import vfcs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  byte_t letter,
	input  logic  final_byte,
	output logic  strobe,
	output byte_t sorted_letter,
	output logic  end_of_string,
	output logic  overflow
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_LOAD  = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	byte_t  mem [MAX_LEN];
	byte_t  rd_data;
	addr_t  rd_addr;
	addr_t  wr_addr;
	byte_t  wr_data;
	logic   wr_en;

	logic [1:0] state_q;
	count_t fill_q;
	logic   drop_q;
	addr_t  idx_q;
	addr_t  ptr_q;
	byte_t  byte_q;
	logic   fin_q;

	logic   accept;
	logic   full;
	logic   place;
	logic   last_out;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full     = (fill_q == CNT_W'(MAX_LEN));
	assign place    = (idx_q == '0) || (sort_key(rd_data) <= sort_key(byte_q));
	assign last_out = ((count_t'(ptr_q) + count_t'(1)) == fill_q);

	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = byte_q;
		case (state_q)
			ST_IDLE: begin
				rd_addr = addr_t'(fill_q - count_t'(1));
			end
			ST_SHIFT: begin
				rd_addr = idx_q - addr_t'(2);
				wr_en   = 1'b1;
				wr_data = place ? byte_q : rd_data;
			end
			ST_LOAD: begin
				rd_addr = '0;
			end
			ST_DRAIN: begin
				rd_addr = ptr_q + addr_t'(1);
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			drop_q  <= 1'b0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) begin
							drop_q  <= 1'b1;
							state_q <= final_byte ? ST_LOAD : ST_IDLE;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (place) begin
						fill_q  <= fill_q + count_t'(1);
						state_q <= fin_q ? ST_LOAD : ST_IDLE;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					strobe <= 1'b1;
					if (last_out) begin
						fill_q  <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= fill_q[ADDR_W-1:0];
			byte_q <= letter;
			fin_q  <= final_byte;
		end
		if ((state_q == ST_SHIFT) && !place) begin
			idx_q <= idx_q - addr_t'(1);
		end
		if (state_q == ST_LOAD) begin
			ptr_q <= '0;
		end
		if (state_q == ST_DRAIN) begin
			ptr_q         <= ptr_q + addr_t'(1);
			sorted_letter <= rd_data;
			end_of_string <= last_out;
			overflow      <= drop_q;
		end
	end

endmodule
